// ===== hdl/ctm_pkg.sv =====
// Package for the codepoint to tile map: field widths, request and status codes,
// the sequencer state type and the control and status structs of a sorted-table cell.
// No dependencies.
`default_nettype none
package ctm_pkg;

  localparam int CP_W        = 21;
  localparam int DIRECT_SIZE = 256;
  localparam int DIRECT_AW   = 8;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_MAP    = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } st_t;

  // Command broadcast to every cell of the sorted chain.
  typedef struct packed {
    logic ins;  // open a gap at the insert point and shift the tail along
    logic upd;  // overwrite the tile of the cell whose codepoint matches
  } cell_ctl_t;

  // Compare flags that each cell reports.
  typedef struct packed {
    logic below;  // occupied and holding a smaller codepoint than the key
    logic hit;    // occupied and holding the key itself
  } cell_stat_t;

endpackage
`default_nettype wire

// ===== hdl/ctm_cell.sv =====
// One cell of the sorted chain: holds a codepoint and its tile, compares against the key
// and, on an insert, takes the key or its left neighbour's entry. Uses ctm_pkg.
`default_nettype none
module ctm_cell #(
  parameter int TILE_BITS = 16
) (
  input  wire                          clk,
  input  ctm_pkg::cell_ctl_t           ctl,
  input  wire                          occ,
  input  wire  [ctm_pkg::CP_W-1:0]     key_cp,
  input  wire  [TILE_BITS-1:0]         key_tile,
  input  wire                          left_below,
  input  wire  [ctm_pkg::CP_W-1:0]     left_cp,
  input  wire  [TILE_BITS-1:0]         left_tile,
  output ctm_pkg::cell_stat_t          stat,
  output logic [ctm_pkg::CP_W-1:0]     cp_q,
  output logic [TILE_BITS-1:0]         tile_q
);
  import ctm_pkg::*;

  logic [CP_W-1:0]      cp_r;
  logic [TILE_BITS-1:0] tile_r;

  assign stat.below = occ && (cp_r < key_cp);
  assign stat.hit   = occ && (cp_r == key_cp);
  assign cp_q       = cp_r;
  assign tile_q     = tile_r;

  // The chain is sorted, so the cells below the key form a prefix. The first cell past
  // that prefix takes the new entry and every later cell takes its neighbour's.
  always_ff @(posedge clk) begin
    if (ctl.ins && !stat.below) begin
      if (left_below) begin
        cp_r   <= key_cp;
        tile_r <= key_tile;
      end else begin
        cp_r   <= left_cp;
        tile_r <= left_tile;
      end
    end else if (ctl.upd && stat.hit) begin
      tile_r <= key_tile;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ctm_direct.sv =====
// Direct table for codepoints below 256: tile memory with registered read and a valid
// flop per entry that reset clears. Uses ctm_pkg.
`default_nettype none
module ctm_direct #(
  parameter int TILE_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              rd_en,
  input  wire  [ctm_pkg::DIRECT_AW-1:0]    rd_addr,
  input  wire                              wr_en,
  input  wire  [ctm_pkg::DIRECT_AW-1:0]    wr_addr,
  input  wire  [TILE_BITS-1:0]             wr_tile,
  output logic                             rd_vld,
  output logic [TILE_BITS-1:0]             rd_tile
);
  import ctm_pkg::*;

  logic [TILE_BITS-1:0]   tile_mem [DIRECT_SIZE];
  logic [DIRECT_SIZE-1:0] vld_r;
  logic                   rd_vld_r;
  logic [TILE_BITS-1:0]   rd_tile_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tile_mem[wr_addr] <= wr_tile;
    end
    if (rd_en) begin
      rd_tile_r <= tile_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_vld  = rd_vld_r;
  assign rd_tile = rd_tile_r;

endmodule
`default_nettype wire

// ===== hdl/codepoint_to_tile_map_top.sv =====
// Codepoint to tile map, top level: request sequencer, direct table and sorted cell chain.
// Depends on ctm_pkg, ctm_direct and ctm_cell.
//
// Usage. A request beat is taken at a rising edge with start high and busy low; it
// carries a lookup or a map of in_code_point to in_tile_number. Exactly one result
// beat follows, shown for one cycle with out_valid high, registered from the execute
// state. The receiver cannot hold results off, so there is no stall on that side.
// An item occupies the block from the accept edge, where the direct table read is
// issued, through the execute state, in which every sorted cell compares its
// codepoint with the key and, on a map, the chain shifts by one cell or one cell
// takes the new tile. busy is high in the execute state, so no new request is
// taken until the block is through with the last one.
// Codepoints below 256 go to the direct table; all others to the sorted chain of
// SORTED_DEPTH cells, kept in ascending codepoint order.
// cfg_wr_en writes the tile count; maps with an index at or above it are rejected.
// Reset clears the tile count, the direct table's valid flags and the chain's fill
// count; no clearing pass is needed and a request may be taken at the first edge
// after reset is released.
`default_nettype none
module codepoint_to_tile_map_top #(
  parameter int SORTED_DEPTH = 256,
  parameter int TILE_BITS    = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_req_type,
  input  wire  [ctm_pkg::CP_W-1:0]     in_code_point,
  input  wire  [TILE_BITS-1:0]         in_tile_number,
  output logic                         out_valid,
  output logic [TILE_BITS-1:0]         out_tile_result,
  output logic                         out_found,
  output logic [1:0]                   out_status,
  input  wire                          cfg_wr_en,
  input  wire  [TILE_BITS:0]           cfg_wr_data
);
  import ctm_pkg::*;

  localparam int UW = $clog2(SORTED_DEPTH + 1);

  st_t                  state_r, state_nxt;
  logic                 exec;
  logic                 accept;

  logic                 type_r;
  logic [CP_W-1:0]      cp_r;
  logic [TILE_BITS-1:0] tile_r;
  logic [TILE_BITS:0]   tile_count_r;
  logic [UW-1:0]        used_r;

  logic                 out_valid_r;
  logic [TILE_BITS-1:0] out_tile_r;
  logic                 out_found_r;
  logic [1:0]           out_status_r;

  logic                 dir_vld;
  logic [TILE_BITS-1:0] dir_tile;

  cell_ctl_t            ctl;
  cell_stat_t           stat   [SORTED_DEPTH];
  logic [CP_W-1:0]      cell_cp   [SORTED_DEPTH];
  logic [TILE_BITS-1:0] cell_tile [SORTED_DEPTH];
  logic [SORTED_DEPTH-1:0] hit_vec;
  logic [SORTED_DEPTH-1:0] below_vec;

  logic                 any_hit;
  logic [TILE_BITS-1:0] hit_tile;
  logic                 is_map;
  logic                 is_high;
  logic                 in_range;
  logic                 full;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        exec = 1'b0;
      end
      ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tile_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        tile_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      type_r <= in_req_type;
      cp_r   <= in_code_point;
      tile_r <= in_tile_number;
    end
  end

  // ---------------- decode of the held request ----------------
  assign is_map   = exec && (type_r == REQ_MAP);
  assign is_high  = |cp_r[CP_W-1:DIRECT_AW];
  assign in_range = {1'b0, tile_r} < tile_count_r;
  assign full     = used_r == UW'(SORTED_DEPTH);

  assign ctl.ins = is_map && in_range && is_high && !any_hit && !full;
  assign ctl.upd = is_map && in_range && is_high && any_hit;

  // ---------------- direct table ----------------
  ctm_direct #(
    .TILE_BITS (TILE_BITS)
  ) u_direct (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_code_point[DIRECT_AW-1:0]),
    .wr_en   (is_map && in_range && !is_high),
    .wr_addr (cp_r[DIRECT_AW-1:0]),
    .wr_tile (tile_r),
    .rd_vld  (dir_vld),
    .rd_tile (dir_tile)
  );

  // ---------------- sorted chain ----------------
  genvar gi;
  generate
    for (gi = 0; gi < SORTED_DEPTH; gi++) begin : g_cell
      logic                 left_below;
      logic [CP_W-1:0]      left_cp;
      logic [TILE_BITS-1:0] left_tile;

      if (gi == 0) begin : g_first
        assign left_below = 1'b1;
        assign left_cp    = cp_r;
        assign left_tile  = tile_r;
      end else begin : g_rest
        assign left_below = below_vec[gi-1];
        assign left_cp    = cell_cp[gi-1];
        assign left_tile  = cell_tile[gi-1];
      end

      ctm_cell #(
        .TILE_BITS (TILE_BITS)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (UW'(gi) < used_r),
        .key_cp     (cp_r),
        .key_tile   (tile_r),
        .left_below (left_below),
        .left_cp    (left_cp),
        .left_tile  (left_tile),
        .stat       (stat[gi]),
        .cp_q       (cell_cp[gi]),
        .tile_q     (cell_tile[gi])
      );

      assign below_vec[gi] = stat[gi].below;
      assign hit_vec[gi]   = stat[gi].hit;
    end
  endgenerate

  // At most one cell matches, so the matching tile is an OR over masked tiles.
  always_comb begin
    hit_tile = '0;
    for (int i = 0; i < SORTED_DEPTH; i++) begin
      hit_tile = hit_tile | (cell_tile[i] & {TILE_BITS{hit_vec[i]}});
    end
  end

  assign any_hit = |hit_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (ctl.ins) begin
      used_r <= used_r + UW'(1);
    end
  end

  // ---------------- result beat ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_tile_r   <= '0;
      out_found_r  <= 1'b0;
      out_status_r <= STAT_OK;
      if (type_r == REQ_LOOKUP) begin
        if (is_high) begin
          out_found_r <= any_hit;
          out_tile_r  <= hit_tile;
        end else if (dir_vld) begin
          out_found_r <= 1'b1;
          out_tile_r  <= dir_tile;
        end
      end else if (!in_range) begin
        out_status_r <= STAT_RANGE;
      end else if (is_high && !any_hit && full) begin
        out_status_r <= STAT_FULL;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tile_result = out_tile_r;
  assign out_found       = out_found_r;
  assign out_status      = out_status_r;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(SORTED_DEPTH))
    else $error("sorted fill count beyond depth");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one sorted cell matches the key");

  a_exec_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid)
    else $error("execute cycle not followed by a result beat");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> used_r == $past(used_r) + UW'(1))
    else $error("insert did not grow the sorted table");

  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == STAT_OK)
    else $error("found flagged with a non-zero status");
`endif

endmodule
`default_nettype wire

// ===== sim/ctm_checker.sv =====
`timescale 1ns / 100ps
// Checker for the codepoint to tile map: watches the request, result and tile-count ports,
// predicts each result beat from its own copy of both tables, and counts mismatches.
// Depends on ctm_pkg.
module ctm_checker #(
  parameter int SORTED_DEPTH = 256,
  parameter int TILE_BITS    = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire                          busy,
  input  wire                          in_req_type,
  input  wire  [ctm_pkg::CP_W-1:0]     in_code_point,
  input  wire  [TILE_BITS-1:0]         in_tile_number,
  input  wire                          out_valid,
  input  wire  [TILE_BITS-1:0]         out_tile_result,
  input  wire                          out_found,
  input  wire  [1:0]                   out_status,
  input  wire                          cfg_wr_en,
  input  wire  [TILE_BITS:0]           cfg_wr_data,
  output int unsigned                  fail_cnt,
  output int unsigned                  waiting
);
  import ctm_pkg::*;

  typedef struct packed {
    logic [TILE_BITS-1:0] tile;
    logic                 found;
    logic [1:0]           status;
  } tile_reply_t;

  logic [TILE_BITS:0]   tile_limit;
  logic                 dir_valid [DIRECT_SIZE];
  logic [TILE_BITS-1:0] dir_tile  [DIRECT_SIZE];
  logic [CP_W-1:0]      chain_cp   [SORTED_DEPTH];
  logic [TILE_BITS-1:0] chain_tile [SORTED_DEPTH];
  int                   chain_fill;
  tile_reply_t          reply_q [$];
  int unsigned          errors  = 0;
  int unsigned          pending = 0;

  assign fail_cnt = errors;
  assign waiting  = pending;

  // Works out the reply to one request and applies any update it makes to the tables.
  function automatic tile_reply_t resolve_request(input logic            is_map,
                                                  input logic [CP_W-1:0] cp,
                                                  input logic [TILE_BITS-1:0] tile);
    tile_reply_t r;
    int          pos;
    int          k;
    bit          hit;
    r   = '0;
    pos = 0;
    if (cp >= DIRECT_SIZE) begin
      while (pos < chain_fill && chain_cp[pos] < cp) pos++;
    end
    hit = (pos < chain_fill) && (chain_cp[pos] == cp);
    if (is_map == REQ_LOOKUP) begin
      if (cp < DIRECT_SIZE) begin
        if (dir_valid[cp[DIRECT_AW-1:0]]) begin
          r.tile  = dir_tile[cp[DIRECT_AW-1:0]];
          r.found = 1'b1;
        end
      end else if (hit) begin
        r.tile  = chain_tile[pos];
        r.found = 1'b1;
      end
    end else if ({1'b0, tile} >= tile_limit) begin
      r.status = STAT_RANGE;
    end else if (cp < DIRECT_SIZE) begin
      dir_valid[cp[DIRECT_AW-1:0]] = 1'b1;
      dir_tile[cp[DIRECT_AW-1:0]]  = tile;
    end else if (hit) begin
      chain_tile[pos] = tile;
    end else if (chain_fill >= SORTED_DEPTH) begin
      r.status = STAT_FULL;
    end else begin
      for (k = chain_fill; k > pos; k--) begin
        chain_cp[k]   = chain_cp[k-1];
        chain_tile[k] = chain_tile[k-1];
      end
      chain_cp[pos]   = cp;
      chain_tile[pos] = tile;
      chain_fill++;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    tile_reply_t want;
    tile_reply_t booked;
    int          i;
    if (!rst_n) begin
      tile_limit = '0;
      chain_fill = 0;
      for (i = 0; i < DIRECT_SIZE; i++) begin
        dir_valid[i] = 1'b0;
        dir_tile[i]  = '0;
      end
      reply_q.delete();
      pending <= 0;
    end else begin
      // Results are retired before this edge's request is booked, as they cannot overlap.
      if (out_valid) begin
        if (reply_q.size() == 0) begin
          report("unexpected result beat, tile", 32'd0, 32'(out_tile_result));
        end else begin
          want = reply_q.pop_front();
          if (out_tile_result !== want.tile)
            report("tile_result", 32'(want.tile), 32'(out_tile_result));
          if (out_found !== want.found)
            report("found", 32'(want.found), 32'(out_found));
          if (out_status !== want.status)
            report("status", 32'(want.status), 32'(out_status));
        end
      end
      if (cfg_wr_en) tile_limit = cfg_wr_data;
      if (start && !busy) begin
        booked  = resolve_request(in_req_type, in_code_point, in_tile_number);
        reply_q = {reply_q, booked};
      end
      pending <= reply_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the codepoint to tile map testbench: clock, reset, request and tile-count stimulus
// and the verdict. Depends on ctm_pkg, codepoint_to_tile_map_top and ctm_checker.
module tb_top;
  import ctm_pkg::*;

  localparam int SORTED_DEPTH = 256;
  localparam int TILE_BITS    = 16;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 start          = 1'b0;
  logic                 in_req_type    = REQ_LOOKUP;
  logic [CP_W-1:0]      in_code_point  = '0;
  logic [TILE_BITS-1:0] in_tile_number = '0;
  logic                 cfg_wr_en      = 1'b0;
  logic [TILE_BITS:0]   cfg_wr_data    = '0;
  wire                  busy;
  wire                  out_valid;
  wire  [TILE_BITS-1:0] out_tile_result;
  wire                  out_found;
  wire  [1:0]           out_status;
  int unsigned          fail_cnt;
  int unsigned          waiting;

  int                   idle_pct = 38;
  int                   tile_cnt = 0;
  logic [CP_W-1:0]      hi_pool [$];

  codepoint_to_tile_map_top #(
    .SORTED_DEPTH(SORTED_DEPTH),
    .TILE_BITS   (TILE_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_code_point  (in_code_point),
    .in_tile_number (in_tile_number),
    .out_valid      (out_valid),
    .out_tile_result(out_tile_result),
    .out_found      (out_found),
    .out_status     (out_status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  ctm_checker #(
    .SORTED_DEPTH(SORTED_DEPTH),
    .TILE_BITS   (TILE_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_code_point  (in_code_point),
    .in_tile_number (in_tile_number),
    .out_valid      (out_valid),
    .out_tile_result(out_tile_result),
    .out_found      (out_found),
    .out_status     (out_status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_cnt       (fail_cnt),
    .waiting        (waiting)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one request beat and returns at the edge that takes it, with start still high.
  task automatic send_beat(input logic rq, input logic [CP_W-1:0] cp,
                           input logic [TILE_BITS-1:0] tn);
    if (idle_pct > 0 && $urandom_range(199) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(20, 5)) @(posedge clk);
    end
    while ($urandom_range(99) < idle_pct) begin
      start          <= 1'b0;
      in_req_type    <= 1'($urandom);
      in_code_point  <= CP_W'($urandom);
      in_tile_number <= TILE_BITS'($urandom);
      @(posedge clk);
    end
    start          <= 1'b1;
    in_req_type    <= rq;
    in_code_point  <= cp;
    in_tile_number <= tn;
    do @(posedge clk); while (busy);
    if (rq == REQ_MAP && cp >= DIRECT_SIZE && hi_pool.size() < 400) hi_pool = {hi_pool, cp};
  endtask

  task automatic drain_replies();
    int k;
    start <= 1'b0;
    @(posedge clk);
    for (k = 0; k < 64 && waiting != 0; k++) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_tile_count(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= (TILE_BITS+1)'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= (TILE_BITS+1)'($urandom);
    tile_cnt    = value;
  endtask

  // Biased request: known high codepoints and their neighbours, the direct range,
  // the edges of the codepoint field, and indices either side of the tile count.
  task automatic random_item();
    logic                 rq;
    logic [CP_W-1:0]      cp;
    logic [TILE_BITS-1:0] tn;
    int                   r;
    rq = ($urandom_range(99) < 45) ? REQ_MAP : REQ_LOOKUP;
    r  = $urandom_range(99);
    if (r < 25) begin
      cp = CP_W'($urandom_range(DIRECT_SIZE - 1));
    end else if (r < 65 && hi_pool.size() > 0) begin
      cp = hi_pool[$urandom_range(hi_pool.size() - 1)];
      if (r >= 55) cp = ($urandom_range(1) != 0) ? cp + 1'b1 : cp - 1'b1;
    end else if (r < 72) begin
      case ($urandom_range(3))
        0: cp = CP_W'(DIRECT_SIZE);
        1: cp = CP_W'(DIRECT_SIZE - 1);
        2: cp = 21'h10FFFF;
        default: cp = '1;
      endcase
    end else begin
      cp = CP_W'($urandom);
    end
    r = $urandom_range(99);
    if (r < 70 && tile_cnt > 0) tn = TILE_BITS'($urandom_range(tile_cnt - 1));
    else if (r < 80 && tile_cnt <= 65535) tn = TILE_BITS'(tile_cnt);
    else tn = TILE_BITS'($urandom);
    send_beat(rq, cp, tn);
  endtask

  initial begin
    int p;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Tile count still zero after reset, so every map is rejected.
    send_beat(REQ_MAP, 21'd5, 16'd0);
    send_beat(REQ_LOOKUP, 21'd5, 16'd0);
    send_beat(REQ_MAP, 21'h1FFFFF, 16'd0);
    drain_replies();

    set_tile_count(65536);
    send_beat(REQ_MAP, 21'd0, 16'hFFFF);
    send_beat(REQ_MAP, 21'd255, 16'd1);
    send_beat(REQ_MAP, 21'd256, 16'h1234);
    send_beat(REQ_MAP, 21'h1FFFFF, 16'hFFFF);
    send_beat(REQ_MAP, 21'h10FFFF, 16'd7);
    send_beat(REQ_MAP, 21'h110000, 16'd9);   // beyond the Unicode range
    send_beat(REQ_MAP, 21'd300, 16'd3);
    send_beat(REQ_MAP, 21'd257, 16'd4);      // lands between existing entries
    send_beat(REQ_LOOKUP, 21'd0, 16'hFFFF);
    send_beat(REQ_LOOKUP, 21'd255, 16'd0);
    send_beat(REQ_LOOKUP, 21'd256, 16'd0);
    send_beat(REQ_LOOKUP, 21'd257, 16'd0);
    send_beat(REQ_LOOKUP, 21'h110000, 16'd0);
    send_beat(REQ_LOOKUP, 21'h1FFFFF, 16'd0);
    send_beat(REQ_LOOKUP, 21'd1, 16'd0);
    send_beat(REQ_LOOKUP, 21'd258, 16'd0);
    send_beat(REQ_MAP, 21'd256, 16'h5555);   // overwrite in the sorted table
    send_beat(REQ_LOOKUP, 21'd256, 16'd0);
    send_beat(REQ_MAP, 21'd255, 16'd0);      // overwrite in the direct table
    send_beat(REQ_LOOKUP, 21'd255, 16'd0);
    drain_replies();

    set_tile_count(100);
    send_beat(REQ_MAP, 21'd10, 16'd100);
    send_beat(REQ_MAP, 21'd10, 16'd99);
    send_beat(REQ_LOOKUP, 21'd10, 16'd0);
    drain_replies();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_tile_count(1);
        1: set_tile_count(65535);
        2: set_tile_count($urandom_range(65536, 1));
        3: set_tile_count(65536);
        4: set_tile_count(0);
        5: set_tile_count(300);
        6: set_tile_count(65536);
        default: set_tile_count($urandom_range(65536, 2));
      endcase
      idle_pct = (p == 1) ? 0 : 38;
      if (p == 3) begin
        // Fresh high codepoints until the sorted table is certainly full.
        for (n = 0; n < SORTED_DEPTH + 24; n++)
          send_beat(REQ_MAP, CP_W'($urandom_range(21'h1FFFFF, DIRECT_SIZE)),
                    TILE_BITS'($urandom));
      end
      for (n = 0; n < 220; n++) begin
        random_item();
        if ($urandom_range(99) == 0) drain_replies();
      end
      drain_replies();
    end

    if (fail_cnt == 0 && waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
